### design/racl_pkg.sv
package racl_pkg;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_valid;
    logic       end_of_text;
  } result_t;

  // Results produced by one accepted text byte: zero, one or two items.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

### design/release_text_ascii_cleaner.sv
// Text byte cleaner: one raw text byte goes in per transfer and cleaned ASCII characters
// come out, one per result transfer, with end_of_text_o set on the last result of each
// text. A byte is decoded in the cycle it is taken and its results appear in the next cycle.
// The block takes one byte per cycle while each byte yields at most one result and results
// are taken; a byte that yields two characters (a bullet becomes a dash and a space) fills
// the two-entry result register, so the next byte waits until the first result has left.
// The byte rate is set by how many results each byte produces and how fast they are taken.
module release_text_ascii_cleaner (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       last_byte_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_valid_o,
  output logic       end_of_text_o
);
  import racl_pkg::*;

  push_t   push;
  result_t res;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  // Byte decoder with its escape and sequence state.
  racl_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push)
  );

  // Result register that feeds the output channel.
  racl_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_i       (push),
    .push_ready_o (in_ready_o),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .res_o        (res)
  );

  assign out_char_o    = res.out_char;
  assign out_valid_o   = res.out_valid;
  assign end_of_text_o = res.end_of_text;

endmodule

### design/racl_decode.sv
module racl_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_byte_i,
  input  logic              last_byte_i,
  output racl_pkg::push_t   push_o
);
  import racl_pkg::*;

  localparam logic [2:0] ModePlain  = 3'd0;
  localparam logic [2:0] ModeBslash = 3'd1;
  localparam logic [2:0] ModeHex    = 3'd2;
  localparam logic [2:0] ModeC2     = 3'd3;
  localparam logic [2:0] ModeE2     = 3'd4;
  localparam logic [2:0] ModeE280   = 3'd5;

  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowerU = 8'h75;

  // Characters gathered while one byte is worked on.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic       prev_sp;
  } emit_t;

  // Appends one character, folding repeated spaces and capping at two.
  function automatic emit_t emit_f(emit_t e, logic [7:0] ch, logic ended);
    emit_t r;
    r = e;
    if (!ended && r.cnt != 2'd2 && !(ch == ChSpace && r.prev_sp)) begin
      r.prev_sp = (ch == ChSpace);
      if (r.cnt == 2'd0) begin
        r.ch0 = ch;
      end else begin
        r.ch1 = ch;
      end
      r.cnt = r.cnt + 2'd1;
    end
    return r;
  endfunction

  logic [2:0]  mode_q, mode_d;
  logic [15:0] hex_q, hex_d;
  logic [1:0]  dig_q, dig_d;
  logic        stop_q, stop_d;
  logic [1:0]  skip_q, skip_d;
  logic        prev_sp_q, prev_sp_d;
  logic        ended_q, ended_d;

  emit_t       e;
  logic        do_plain;
  logic        do_code;
  logic [15:0] code;
  logic [2:0]  dig_inc;
  logic        d_ok;
  logic [3:0]  d_val;
  logic [7:0]  b;
  push_t       push;

  assign b = text_byte_i;

  // Hex digit recognition, either case.
  always_comb begin
    d_ok  = 1'b1;
    d_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d_val = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d_val = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d_val = 4'(b - 8'h57);
    end else begin
      d_ok = 1'b0;
    end
  end

  // Next state and results for the byte at the input.
  always_comb begin
    mode_d   = mode_q;
    hex_d    = hex_q;
    dig_d    = dig_q;
    stop_d   = stop_q;
    skip_d   = skip_q;
    ended_d  = ended_q;
    e        = '{cnt: 2'd0, ch0: 8'd0, ch1: 8'd0, prev_sp: prev_sp_q};
    do_plain = 1'b0;
    do_code  = 1'b0;
    code     = hex_q;
    dig_inc  = {1'b0, dig_q} + 3'd1;

    if (!ended_q) begin
      unique case (mode_q)
        ModeBslash: begin
          mode_d = ModePlain;
          if (b == ChLowerU) begin
            mode_d = ModeHex;
            hex_d  = 16'd0;
            dig_d  = 2'd0;
            stop_d = 1'b0;
          end else begin
            e        = emit_f(e, ChBslash, ended_d);
            do_plain = 1'b1;
          end
        end
        ModeHex: begin
          if (!stop_q && d_ok) begin
            hex_d = {hex_q[11:0], d_val};
          end else begin
            stop_d = 1'b1;
          end
          dig_d = dig_inc[1:0];
          if (dig_inc[2]) begin
            mode_d  = ModePlain;
            code    = hex_d;
            do_code = 1'b1;
            hex_d   = 16'd0;
            dig_d   = 2'd0;
            stop_d  = 1'b0;
          end
        end
        ModeC2: begin
          mode_d = ModePlain;
          if (b == 8'hA0) begin
            e = emit_f(e, ChSpace, ended_d);
          end
        end
        ModeE2: begin
          if (b == 8'h80) begin
            mode_d = ModeE280;
          end else begin
            mode_d = ModePlain;
            skip_d = 2'd1;
          end
        end
        ModeE280: begin
          mode_d = ModePlain;
          if (b == 8'hA2) begin
            e = emit_f(e, ChDash, ended_d);
            e = emit_f(e, ChSpace, ended_d);
          end else if (b == 8'h93 || b == 8'h94) begin
            e = emit_f(e, ChDash, ended_d);
          end else if (b == 8'h83) begin
            e = emit_f(e, ChSpace, ended_d);
          end
        end
        default: begin
          mode_d   = ModePlain;
          do_plain = 1'b1;
        end
      endcase
    end

    // A completed escape maps its code point.
    if (do_code) begin
      if (code == 16'h2022) begin
        e = emit_f(e, ChDash, ended_d);
        e = emit_f(e, ChSpace, ended_d);
      end else if (code == 16'h2013 || code == 16'h2014) begin
        e = emit_f(e, ChDash, ended_d);
      end else if (code == 16'h00A0 || code == 16'h2003 || code == 16'h2002) begin
        e = emit_f(e, ChSpace, ended_d);
      end else if (code == 16'h0000) begin
        ended_d = 1'b1;
      end else if (code < 16'h0080) begin
        e = emit_f(e, code[7:0], ended_d);
      end
    end

    // Ordinary byte handling, including lead bytes of skipped sequences.
    if (do_plain) begin
      if (skip_q != 2'd0) begin
        skip_d = skip_q - 2'd1;
      end else if (b == 8'h00) begin
        ended_d = 1'b1;
      end else if (b == ChBslash) begin
        mode_d = ModeBslash;
      end else if (b == 8'hE2) begin
        mode_d = ModeE2;
      end else if (b == 8'hC2) begin
        mode_d = ModeC2;
      end else if (b >= 8'hC0) begin
        skip_d = (b < 8'hE0) ? 2'd1 : (b < 8'hF0) ? 2'd2 : 2'd3;
      end else begin
        e = emit_f(e, b, ended_d);
      end
    end

    // End of text: a trailing backslash is copied, then everything resets.
    if (last_byte_i && !ended_d && mode_d == ModeBslash) begin
      e = emit_f(e, ChBslash, ended_d);
    end

    push.cnt = e.cnt;
    push.r0  = '{out_char: e.ch0, out_valid: 1'b1, end_of_text: 1'b0};
    push.r1  = '{out_char: e.ch1, out_valid: 1'b1, end_of_text: 1'b0};
    prev_sp_d = e.prev_sp;

    if (last_byte_i) begin
      if (e.cnt == 2'd0) begin
        push.cnt = 2'd1;
        push.r0  = '{out_char: 8'd0, out_valid: 1'b0, end_of_text: 1'b1};
      end else if (e.cnt == 2'd1) begin
        push.r0.end_of_text = 1'b1;
      end else begin
        push.r1.end_of_text = 1'b1;
      end
      mode_d    = ModePlain;
      hex_d     = 16'd0;
      dig_d     = 2'd0;
      stop_d    = 1'b0;
      skip_d    = 2'd0;
      prev_sp_d = 1'b0;
      ended_d   = 1'b0;
    end
  end

  assign push_o = push;

  // Decoder state, advanced on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModePlain;
      hex_q     <= 16'd0;
      dig_q     <= 2'd0;
      stop_q    <= 1'b0;
      skip_q    <= 2'd0;
      prev_sp_q <= 1'b0;
      ended_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      hex_q     <= hex_d;
      dig_q     <= dig_d;
      stop_q    <= stop_d;
      skip_q    <= skip_d;
      prev_sp_q <= prev_sp_d;
      ended_q   <= ended_d;
    end
  end

  // The final byte of a text always yields at least one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |-> push_o.cnt != 2'd0)
    else $error("final byte produced no result");

  // After the final byte the decoder is back in plain text mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> mode_q == ModePlain && !ended_q && skip_q == 2'd0)
    else $error("decoder state not cleared after end of text");

endmodule

### design/racl_outbuf.sv
module racl_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  racl_pkg::push_t   push_i,
  output logic              push_ready_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output racl_pkg::result_t res_o
);
  import racl_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  result_t    slot0_q, slot0_d;
  result_t    slot1_q, slot1_d;
  logic       pop;
  logic       push;

  assign res_valid_o  = (cnt_q != 2'd0);
  assign res_o        = slot0_q;
  assign pop          = res_valid_o && res_ready_i;
  // Room for two new results once the buffer drains this cycle.
  assign push_ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && res_ready_i);
  assign push         = push_valid_i && push_ready_o;

  // Two-entry result register: slot 0 is always the head.
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (push) begin
      cnt_d   = push_i.cnt;
      slot0_d = push_i.r0;
      slot1_d = push_i.r1;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  // The buffer never holds more than two results.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("result buffer overflow");

  // A full buffer never takes a new byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push_ready_o)
    else $error("byte accepted while result buffer full");

endmodule
